// ===== src/ptbm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptbm_pkg
// Shared types and constants for the packed triangular block multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbm_pkg;

   localparam int MAX_BLOCK       = 8;
   localparam int BLOCK_IDX_BITS  = 3;
   localparam int BLOCK_SIZE_BITS = 4;
   localparam int VALUE_BITS      = 16;
   localparam int PROD_BITS       = 2 * VALUE_BITS;
   localparam int SUM_BITS        = 40;
   localparam int STORE_ADDR_BITS = 11;
   localparam int START_BITS      = 8;
   localparam int MSIZE_BITS      = 9;
   localparam int K_BITS          = 9;
   localparam int OP_BITS         = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 9;

   localparam logic [SUM_BITS-1:0] SUM_LIMIT = {SUM_BITS{1'b1}};

   // Operation codes.
   localparam logic [OP_BITS-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_COMPUTE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_START   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_START   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_SIZE  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATRIX_SIZE = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]         operation;
      logic [STORE_ADDR_BITS-1:0] element_index;
      logic [VALUE_BITS-1:0]      element_value;
   } req_type;

   typedef struct packed {
      logic [BLOCK_IDX_BITS-1:0]  result_row;
      logic [BLOCK_IDX_BITS-1:0]  result_col;
      logic [STORE_ADDR_BITS-1:0] result_offset;
      logic [SUM_BITS-1:0]        result_value;
      logic                       last;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic write_a;
      logic write_b;
      logic clear_block;
      logic step_k;
      logic emit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic k_last;
      logic elem_last;
      logic pipe_empty;
      logic out_free;
      logic bs_zero;
   } status_type;

endpackage

`default_nettype wire

// ===== src/packed_triangular_block_matmul_top.sv =====
// ----------------------------------------------------------------------------
// packed_triangular_block_matmul_top
// Triangular-aware block multiply over packed A row and B column stores.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       req_valid / req_stall  req_data    (operation, index, value)
//  rsp       rsp_valid / rsp_stall  rsp_data    (row, col, offset, value, last)
//  csr       csr_write_enable       csr_index, csr_write_data
//
//  Load requests are accepted one per cycle while req_stall is low. A compute
//  request produces min(block_size, 8)^2 results; element (i, j) sums over
//  k = 0 .. min(row_start+i, col_start+j), the single multiply-accumulate
//  unit reading one A and one B store entry per cycle while issuing.
//  req_stall is high for the whole compute; the result register lets the
//  next element proceed while a result waits under rsp_stall.
//  Reset is synchronous; the stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_triangular_block_matmul_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ptbm_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ptbm_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_write_enable,
   input  wire logic [ptbm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ptbm_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   ptbm_pkg::cmd_type    cmd;
   ptbm_pkg::status_type status;

   ptbm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   ptbm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/ptbm_store.sv =====
// ----------------------------------------------------------------------------
// ptbm_store
// Packed element store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbm_store (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [ptbm_pkg::STORE_ADDR_BITS-1:0] wr_addr,
   input  wire logic [ptbm_pkg::VALUE_BITS-1:0]      wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [ptbm_pkg::STORE_ADDR_BITS-1:0] rd_addr,
   output logic      [ptbm_pkg::VALUE_BITS-1:0]      rd_data
);

   localparam int DEPTH = 1 << ptbm_pkg::STORE_ADDR_BITS;

   logic [ptbm_pkg::VALUE_BITS-1:0] mem [DEPTH];
   logic [ptbm_pkg::VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/ptbm_datapath.sv =====
// ----------------------------------------------------------------------------
// ptbm_datapath
// Configuration registers, index walk, element stores, multiply-accumulate
// pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ptbm_pkg::cmd_type                   cmd,
   output ptbm_pkg::status_type                     status,
   input  wire ptbm_pkg::req_type                   req_data,
   input  wire logic                                csr_write_enable,
   input  wire logic [ptbm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ptbm_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ptbm_pkg::rsp_type                        rsp_data
);

   localparam int AW = ptbm_pkg::STORE_ADDR_BITS;
   localparam int IW = ptbm_pkg::BLOCK_IDX_BITS;
   localparam int KW = ptbm_pkg::K_BITS;
   localparam int SW = ptbm_pkg::SUM_BITS;
   localparam int PW = ptbm_pkg::PROD_BITS;

   // Configuration registers.
   logic [ptbm_pkg::START_BITS-1:0]      row_start_ff, col_start_ff;
   logic [ptbm_pkg::BLOCK_SIZE_BITS-1:0] block_size_ff;
   logic [ptbm_pkg::MSIZE_BITS-1:0]      matrix_size_ff;

   // Walk state.
   logic [IW-1:0] i_ff, j_ff;
   logic [KW-1:0] k_ff;
   logic [AW-1:0] base_a_ff, base_b_ff, row_off_ff;

   // Pipeline.
   logic          rd_valid_ff, prod_valid_ff;
   logic [PW-1:0] prod_ff;
   logic [SW-1:0] acc_ff, acc_in;
   logic [SW:0]   acc_sum;

   logic                 rsp_valid_ff;
   ptbm_pkg::rsp_type    rsp_data_ff;

   logic [ptbm_pkg::BLOCK_SIZE_BITS-1:0] bs_eff;
   logic [IW-1:0]                        last_idx;
   logic [KW-1:0]                        ga, gb, kmax;
   logic [AW-1:0]                        a_addr, b_addr;
   logic [ptbm_pkg::VALUE_BITS-1:0]      a_q, b_q;
   logic                                 col_last, row_last, out_free;

   always_comb begin
      if (block_size_ff > ptbm_pkg::BLOCK_SIZE_BITS'(ptbm_pkg::MAX_BLOCK)) begin
         bs_eff = ptbm_pkg::BLOCK_SIZE_BITS'(ptbm_pkg::MAX_BLOCK);
      end else begin
         bs_eff = block_size_ff;
      end
      last_idx = IW'(bs_eff - ptbm_pkg::BLOCK_SIZE_BITS'(1));
      ga       = KW'(row_start_ff) + KW'(i_ff);
      gb       = KW'(col_start_ff) + KW'(j_ff);
      kmax     = (ga < gb) ? ga : gb;
      a_addr   = base_a_ff + AW'(k_ff);
      b_addr   = base_b_ff + AW'(k_ff);
      col_last = (j_ff == last_idx);
      row_last = (i_ff == last_idx);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign status.k_last     = (k_ff == kmax);
   assign status.elem_last  = col_last && row_last;
   assign status.pipe_empty = !rd_valid_ff && !prod_valid_ff;
   assign status.out_free   = out_free;
   assign status.bs_zero    = (block_size_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_start_ff   <= '0;
         col_start_ff   <= '0;
         block_size_ff  <= ptbm_pkg::BLOCK_SIZE_BITS'(ptbm_pkg::MAX_BLOCK);
         matrix_size_ff <= ptbm_pkg::MSIZE_BITS'(256);
      end else if (csr_write_enable) begin
         case (csr_index)
            ptbm_pkg::CSR_ROW_START: begin
               row_start_ff <= csr_write_data[ptbm_pkg::START_BITS-1:0];
            end
            ptbm_pkg::CSR_COL_START: begin
               col_start_ff <= csr_write_data[ptbm_pkg::START_BITS-1:0];
            end
            ptbm_pkg::CSR_BLOCK_SIZE: begin
               block_size_ff <= csr_write_data[ptbm_pkg::BLOCK_SIZE_BITS-1:0];
            end
            ptbm_pkg::CSR_MATRIX_SIZE: begin
               matrix_size_ff <= csr_write_data[ptbm_pkg::MSIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Row bases advance by row_start+i+1 per row, which is the packed
   // triangular layout; column bases likewise with col_start+j+1.
   always_ff @(posedge clock) begin
      if (cmd.clear_block) begin
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         base_a_ff  <= '0;
         base_b_ff  <= '0;
         row_off_ff <= '0;
      end else if (cmd.emit) begin
         k_ff <= '0;
         if (col_last) begin
            j_ff       <= '0;
            base_b_ff  <= '0;
            i_ff       <= i_ff + IW'(1);
            base_a_ff  <= base_a_ff + AW'(row_start_ff) + AW'(i_ff) + AW'(1);
            row_off_ff <= row_off_ff + AW'(matrix_size_ff);
         end else begin
            j_ff      <= j_ff + IW'(1);
            base_b_ff <= base_b_ff + AW'(col_start_ff) + AW'(j_ff) + AW'(1);
         end
      end else if (cmd.step_k) begin
         k_ff <= k_ff + KW'(1);
      end
   end

   ptbm_store u_store_a (
      .clock   (clock),
      .wr_en   (cmd.write_a),
      .wr_addr (req_data.element_index),
      .wr_data (req_data.element_value),
      .rd_en   (cmd.step_k),
      .rd_addr (a_addr),
      .rd_data (a_q)
   );

   ptbm_store u_store_b (
      .clock   (clock),
      .wr_en   (cmd.write_b),
      .wr_addr (req_data.element_index),
      .wr_data (req_data.element_value),
      .rd_en   (cmd.step_k),
      .rd_addr (b_addr),
      .rd_data (b_q)
   );

   // The sum saturates; it fits in 41 bits before the clamp.
   always_comb begin
      acc_sum = {1'b0, acc_ff} + (SW + 1)'(prod_ff);
      acc_in  = acc_sum[SW] ? ptbm_pkg::SUM_LIMIT : acc_sum[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.step_k;
         prod_valid_ff <= rd_valid_ff;
      end
      prod_ff <= PW'(a_q) * PW'(b_q);
      if (cmd.clear_block || cmd.emit) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff.result_row    <= i_ff;
         rsp_data_ff.result_col    <= j_ff;
         rsp_data_ff.result_offset <= row_off_ff + AW'(col_start_ff) + AW'(j_ff);
         rsp_data_ff.result_value  <= acc_ff;
         rsp_data_ff.last          <= col_last && row_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result must not be taken while products are still in flight.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rd_valid_ff && !prod_valid_ff))
      else $error("result emitted with accumulation pending");

   // The walk never reads past the triangular bound of the element.
   assert property (@(posedge clock) disable iff (reset)
      cmd.step_k |-> (k_ff <= kmax))
      else $error("k walk ran past its bound");

   // An emitted result must not overwrite one that is still held.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== src/ptbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptbm_ctrl
// Sequencer: accepts requests, walks each block element through the
// multiply-accumulate pipeline and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbm_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [ptbm_pkg::OP_BITS-1:0]  req_operation,
   output logic                               req_stall,
   input  wire ptbm_pkg::status_type          status,
   output ptbm_pkg::cmd_type                  cmd
);

   typedef enum logic [1:0] {
      IDLE,
      ISSUE,
      DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.write_a     = accept && (req_operation == ptbm_pkg::OP_LOAD_A);
      cmd.write_b     = accept && (req_operation == ptbm_pkg::OP_LOAD_B);
      case (state_ff)
         IDLE: begin
            if (accept && (req_operation == ptbm_pkg::OP_COMPUTE)
                && !status.bs_zero) begin
               cmd.clear_block = 1'b1;
               state_in        = ISSUE;
            end
         end
         ISSUE: begin
            cmd.step_k = 1'b1;
            if (status.k_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            if (status.pipe_empty && status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.elem_last ? IDLE : ISSUE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Stores are only written while no compute is in progress.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.write_a || cmd.write_b) |-> (state_ff == IDLE) && !cmd.step_k)
      else $error("store write during compute");

endmodule

`default_nettype wire
